>>> rtl/core/multi_waveform_oscillator_assert.svh
// assertion macros for the oscillator checker
// expects clk and rst_n in the scope of each use
`ifndef MULTI_WAVEFORM_OSCILLATOR_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_ASSERT_SVH

// same-cycle implication
`define MWO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mwo_pkg.sv
// types and constants for the multi-waveform oscillator
// no dependencies
package mwo_pkg;

  localparam int U_W        = 32;  // width of the phase word the shapes work on
  localparam int STEP_W     = 32;
  localparam int DUTY_W     = 16;
  localparam int COUNT_W    = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    WAVE_SINE  = 2'd0,
    WAVE_SAW   = 2'd1,
    WAVE_TRI   = 2'd2,
    WAVE_PULSE = 2'd3
  } wave_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DUTY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd3;

  localparam logic [DUTY_W-1:0]  DUTY_RESET  = 16'd32768;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 24'd1;

  // pi/2 in Q30, and the Taylor denominators (2n)(2n+1) for the sine table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  typedef struct packed {
    wave_t             wave;
    logic [DUTY_W-1:0] duty;
  } shape_cfg_t;

endpackage

>>> rtl/core/mwo_shape.sv
// waveform shaper: maps a 32-bit phase word to one signed sample
// uses mwo_pkg; sine comes from a quarter-wave constant table built at elaboration
module mwo_shape import mwo_pkg::*; #(
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  shape_cfg_t             cfg,
  input  logic [U_W-1:0]         u,
  output logic [SAMPLE_BITS-1:0] sample
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = U_W + SAMPLE_BITS;
  localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [SAMPLE_BITS-1:0] FS = FULL_SCALE[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS:0]   FS_EXT = FULL_SCALE[SAMPLE_BITS:0];
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [PROD_W-1:0] RND_SAW = PROD_W'(64'd1 << 30);
  localparam logic [PROD_W-1:0] RND_TRI = PROD_W'(64'd1 << 29);

  typedef logic [SAMPLE_BITS-1:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      rom[k] = v[SAMPLE_BITS-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // sine path
  logic [30+IDX_W-1:0]     idx_prod;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        rom_addr;
  logic [SAMPLE_BITS-1:0]  rom_val;
  logic [SAMPLE_BITS-1:0]  sine_val;

  assign idx_prod = (30+IDX_W)'(u[29:0]) * (30+IDX_W)'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[30 +: IDX_W];
  assign rom_addr = u[30] ? (DEPTH_IDX - idx) : idx;
  assign rom_val  = SINE_ROM[rom_addr];
  assign sine_val = u[31] ? (~rom_val + 1'b1) : rom_val;

  // sawtooth and triangle share one multiply by full scale
  logic                   tri_lo;
  logic                   tri_mid;
  logic [U_W-1:0]         mul_op;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      saw_sum;
  logic [PROD_W-1:0]      tri_sum;
  logic [SAMPLE_BITS:0]   saw_mag;
  logic [SAMPLE_BITS:0]   tri_r;
  logic [SAMPLE_BITS:0]   saw_val;
  logic [SAMPLE_BITS:0]   tri_val;

  assign tri_lo  = (u <= 32'h4000_0000);
  assign tri_mid = (u <= 32'hC000_0000);

  always_comb begin
    if (cfg.wave == WAVE_SAW || tri_lo) begin
      mul_op = u;
    end else if (tri_mid) begin
      mul_op = u - 32'h4000_0000;
    end else begin
      mul_op = ~u + 32'd1;  // 2^32 - u, nonzero here
    end
  end

  assign prod    = PROD_W'(mul_op) * PROD_W'(FS);
  assign saw_sum = prod + RND_SAW;
  assign tri_sum = prod + RND_TRI;
  assign saw_mag = saw_sum[31 +: SAMPLE_BITS+1];
  assign tri_r   = tri_sum[30 +: SAMPLE_BITS+1];
  assign saw_val = saw_mag - FS_EXT;

  always_comb begin
    if (tri_lo) begin
      tri_val = ~tri_r + 1'b1;
    end else if (tri_mid) begin
      tri_val = tri_r - FS_EXT;
    end else begin
      tri_val = tri_r;
    end
  end

  always_comb begin
    case (cfg.wave)
      WAVE_SINE:  sample = sine_val;
      WAVE_SAW:   sample = saw_val[SAMPLE_BITS-1:0];
      WAVE_TRI:   sample = tri_val[SAMPLE_BITS-1:0];
      WAVE_PULSE: sample = (u <= {cfg.duty, 16'h0000}) ? FS : (~FS + 1'b1);
      default:    sample = '0;
    endcase
  end

endmodule

>>> rtl/core/multi_waveform_oscillator.sv
// an accepted transaction passes the phase register, then the shaper and output register, to out_valid
// throughput: one sample per cycle while out_stall is low, limited by the single shaper pass and its multiply
// the output register and the phase stage let input be taken while a result waits
// reset (rst_n low, synchronous): config back to defaults, phase and sample index cleared,
// pipeline emptied; the sine table is constant and needs no fill
module multi_waveform_oscillator import mwo_pkg::*; #(
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_restart,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic                   out_last
);

  // configuration registers
  wave_t              wave_type_r;
  logic [STEP_W-1:0]  phase_step_r;
  logic [DUTY_W-1:0]  pulse_duty_r;
  logic [COUNT_W-1:0] sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_type_r    <= WAVE_SINE;
      phase_step_r   <= '0;
      pulse_duty_r   <= DUTY_RESET;
      sample_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAVE_TYPE:    wave_type_r    <= wave_t'(cfg_wdata[1:0]);
        CFG_PHASE_STEP:   phase_step_r   <= cfg_wdata[STEP_W-1:0];
        CFG_PULSE_DUTY:   pulse_duty_r   <= cfg_wdata[DUTY_W-1:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // phase step truncated or zero-extended to the accumulator width
  logic [PHASE_BITS-1:0] step;
  generate
    if (PHASE_BITS >= STEP_W) begin : g_step_wide
      assign step = PHASE_BITS'(phase_step_r);
    end else begin : g_step_narrow
      assign step = phase_step_r[PHASE_BITS-1:0];
    end
  endgenerate

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic out_ready;
  logic s1_ready;
  logic in_accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // phase accumulator and run counter
  logic [PHASE_BITS-1:0] phase_r, phase_nxt, base_phase;
  logic [COUNT_W-1:0]    index_r, index_nxt, base_index;
  logic                  last;
  logic [U_W-1:0]        u;

  assign base_phase = in_restart ? '0 : phase_r;
  assign base_index = in_restart ? '0 : index_r;
  assign last       = ({1'b0, base_index} + 1'b1) >= {1'b0, sample_count_r};

  generate
    if (PHASE_BITS >= U_W) begin : g_top_wide
      assign u = base_phase[PHASE_BITS-1 -: U_W];
    end else begin : g_top_narrow
      assign u = {base_phase, {(U_W-PHASE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    phase_nxt = phase_r;
    index_nxt = index_r;
    if (in_accept) begin
      if (last) begin
        phase_nxt = '0;
        index_nxt = '0;
      end else begin
        phase_nxt = base_phase + step;
        index_nxt = base_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      index_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      index_r <= index_nxt;
    end
  end

  // phase stage
  logic [U_W-1:0] s1_u_r;
  logic           s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_u_r    <= u;
      s1_last_r <= last;
    end
  end

  // shaper and output register
  shape_cfg_t             shape_cfg;
  logic [SAMPLE_BITS-1:0] shaped;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   last_r;

  assign shape_cfg.wave = wave_type_r;
  assign shape_cfg.duty = pulse_duty_r;

  mwo_shape #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_shape (
    .cfg    (shape_cfg),
    .u      (s1_u_r),
    .sample (shaped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      sample_r <= shaped;
      last_r   <= s1_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_last   = last_r;

endmodule

>>> rtl/core/mwo_checker.sv
// port-level checks for the multi-waveform oscillator, bound to the top level
// uses multi_waveform_oscillator_assert.svh and mwo_pkg
`include "multi_waveform_oscillator_assert.svh"

module mwo_checker import mwo_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_last
);

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a held result keeps its payload
  `MWO_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_sample) && $stable(out_last), "stalled result changed")

  // samples stay within plus and minus full scale
  `MWO_ASSERT_NOW(a_sample_range, out_valid, out_sample != MOST_NEG,
    "sample below negative full scale")

  // input is only held off when a result is waiting
  `MWO_ASSERT_NOW(a_stall_cause, in_stall, out_valid,
    "input stalled with empty output")

  // pipeline comes out of reset empty
  `MWO_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid && !in_stall,
    "pipeline not empty after reset")

endmodule

bind multi_waveform_oscillator mwo_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mwo_checker (.*);
